/* src/b2da_pkg.sv */
// Package: shared constants for the binary to decimal ASCII converter.
package b2da_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 32;

    // One BCD digit.
    localparam int NIBBLE_W = 4;

    // A digit at or above this level is corrected before the next shift.
    localparam logic [NIBBLE_W-1:0] DABBLE_LIMIT = 4'd5;
    localparam logic [NIBBLE_W-1:0] DABBLE_ADD   = 4'd3;

    localparam int CHAR_W = 6;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

endpackage

/* src/b2da_dabble_step.sv */
// One shift-and-add-3 step of the binary to BCD conversion.
module b2da_dabble_step #(
    parameter int DIGITS = 10
) (
    input  logic [DIGITS*b2da_pkg::NIBBLE_W-1:0] bcd,
    input  logic                                 bit_in,
    output logic [DIGITS*b2da_pkg::NIBBLE_W-1:0] bcd_next
);

    logic [DIGITS*b2da_pkg::NIBBLE_W-1:0] adjusted;

    // Correct every digit of five or more, then shift in the next binary bit.
    always_comb
    begin
        for (int d = 0; d < DIGITS; d++)
        begin
            if (bcd[d*b2da_pkg::NIBBLE_W +: b2da_pkg::NIBBLE_W] >= b2da_pkg::DABBLE_LIMIT)
            begin
                adjusted[d*b2da_pkg::NIBBLE_W +: b2da_pkg::NIBBLE_W] =
                    bcd[d*b2da_pkg::NIBBLE_W +: b2da_pkg::NIBBLE_W] + b2da_pkg::DABBLE_ADD;
            end
            else
            begin
                adjusted[d*b2da_pkg::NIBBLE_W +: b2da_pkg::NIBBLE_W] =
                    bcd[d*b2da_pkg::NIBBLE_W +: b2da_pkg::NIBBLE_W];
            end
        end
    end

    assign bcd_next = {adjusted[DIGITS*b2da_pkg::NIBBLE_W-2:0], bit_in};

endmodule

/* src/binary_to_decimal_ascii.sv */
// Top level: binary word to decimal ASCII text, one character per output item.
// The sign is registered at the accept and appears in the cycle after it; each digit
// follows the bit-serial conversion (S_CONV) and leading-zero skip (S_SKIP), and is
// registered out from S_EMIT as output stalls allow. A new number is taken only in
// S_IDLE, after the last digit. The single shared dabble step converts one bit per cycle.
// Reset: rst_n clears the sequencer and output valid at once; nothing else is kept.
module binary_to_decimal_ascii #(
    parameter int VALUE_WIDTH = b2da_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // s_tdata: value [VALUE_WIDTH-1:0], zero fill to whole bytes
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]       s_tdata,
    // s_tuser: mode [0] (0 unsigned, 1 signed)
    input  logic                                   s_tuser,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // m_tdata: char_code [5:0], zero fill [7:6]
    output logic [7:0]                             m_tdata,
    output logic                                   m_tlast,
    output logic                                   m_tvalid,
    input  logic                                   m_tready
);

    // Decimal digits needed for a VALUE_WIDTH-bit magnitude (1233/4096 ~ log10 2).
    localparam int DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
    localparam int BCD_W  = DIGITS * b2da_pkg::NIBBLE_W;
    localparam int CNT_W  = $clog2(VALUE_WIDTH);
    localparam int DIG_W  = $clog2(DIGITS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_SKIP = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t                       state_reg, state_next;
    logic [VALUE_WIDTH-1:0]       bin_reg, bin_next;
    logic [BCD_W-1:0]             bcd_reg, bcd_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [DIG_W-1:0]             dig_reg, dig_next;
    logic                         out_valid_reg, out_valid_next;
    logic [b2da_pkg::CHAR_W-1:0]  out_char_reg, out_char_next;
    logic                         out_last_reg, out_last_next;

    logic [VALUE_WIDTH-1:0]       word;
    logic                         negative;
    logic [VALUE_WIDTH-1:0]       magnitude;
    logic [BCD_W-1:0]             step_bcd;
    logic [b2da_pkg::NIBBLE_W-1:0] top_digit;
    logic                         out_free;
    logic                         in_accept;

    // The output slot is free when empty or being taken this cycle.
    assign out_free  = !out_valid_reg || m_tready;
    // Take a new number only when idle and the sign can go straight out.
    assign s_tready  = (state_reg == S_IDLE) && out_free;
    assign in_accept = s_tvalid && s_tready;

    assign word     = s_tdata[VALUE_WIDTH-1:0];
    assign negative = s_tuser && word[VALUE_WIDTH-1];
    // The most negative word negates to itself, which is its correct magnitude
    // when read as unsigned.
    assign magnitude = negative ? (~word + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : word;

    assign top_digit = bcd_reg[BCD_W-1 -: b2da_pkg::NIBBLE_W];

    // Shared conversion step: correct digits, shift in the binary MSB.
    b2da_dabble_step #(
        .DIGITS (DIGITS)
    ) u_step (
        .bcd      (bcd_reg),
        .bit_in   (bin_reg[VALUE_WIDTH-1]),
        .bcd_next (step_bcd)
    );

    always_comb
    begin
        state_next     = state_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        cnt_next       = cnt_reg;
        dig_next       = dig_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    bin_next   = magnitude;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = S_CONV;
                    // Put the sign out while the digits are being formed.
                    if (negative)
                    begin
                        out_valid_next = 1'b1;
                        out_char_next  = b2da_pkg::CHAR_MINUS;
                        out_last_next  = 1'b0;
                    end
                end
            end
            S_CONV:
            begin
                bcd_next = step_bcd;
                bin_next = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(VALUE_WIDTH - 1))
                begin
                    dig_next   = DIG_W'(DIGITS);
                    state_next = S_SKIP;
                end
            end
            S_SKIP:
            begin
                // Drop leading zeros, keeping at least one digit.
                if (top_digit == '0 && dig_reg > DIG_W'(1))
                begin
                    bcd_next = {bcd_reg[BCD_W-b2da_pkg::NIBBLE_W-1:0],
                                {b2da_pkg::NIBBLE_W{1'b0}}};
                    dig_next = dig_reg - 1'b1;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = b2da_pkg::CHAR_ZERO
                                     + {{(b2da_pkg::CHAR_W-b2da_pkg::NIBBLE_W){1'b0}}, top_digit};
                    out_last_next  = (dig_reg == DIG_W'(1));
                    bcd_next = {bcd_reg[BCD_W-b2da_pkg::NIBBLE_W-1:0],
                                {b2da_pkg::NIBBLE_W{1'b0}}};
                    dig_next = dig_reg - 1'b1;
                    if (dig_reg == DIG_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg      <= bin_next;
        bcd_reg      <= bcd_next;
        cnt_reg      <= cnt_next;
        dig_reg      <= dig_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8-b2da_pkg::CHAR_W){1'b0}}, out_char_reg};
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_conv_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CONV |-> cnt_reg <= CNT_W'(VALUE_WIDTH - 1))
        else $error("bit counter ran past the word width");

    a_digits_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SKIP || state_reg == S_EMIT) |-> dig_reg != '0)
        else $error("digit count empty while digits remain to emit");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free && dig_reg == DIG_W'(1))
        |=> (state_reg == S_IDLE && m_tvalid && m_tlast))
        else $error("final digit did not close the number");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[5:0] == b2da_pkg::CHAR_MINUS && !m_tlast)
                      || (m_tdata[5:0] >= b2da_pkg::CHAR_ZERO
                          && m_tdata[5:0] <= b2da_pkg::CHAR_NINE)))
        else $error("output character is neither a digit nor a leading sign");
`endif

endmodule
